[design/hcsw_pkg.sv]
// Shared types, constants and microcode for the hybrid CA state-space walker.
// Used by hcsw_dp and hybrid_ca_state_space_walker; no dependencies.
package hcsw_pkg;

    localparam int MAX_CELLS_DEF = 16;
    localparam int RULE_CELLS    = 16;
    localparam int CELLS_W       = 16;
    localparam int RULE_W        = 8;
    localparam int CNT_W         = 5;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int STEP_W        = 5;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RULES_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RULES_HIGH = 2'd2;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_STEP,
        OP_MARK,
        OP_ROW_ZERO,
        OP_READ_ROW,
        OP_ROW_INC,
        OP_SET_FIN,
        OP_TAKE_TGT,
        OP_LOAD_TGT,
        OP_CLR_INIT,
        OP_CLR_WR
    } op_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_IN_RESTART,
        C_FINISHED,
        C_SEEN,
        C_FOUND,
        C_MORE_ROWS,
        C_MORE_ALL,
        C_NOT_RESTART
    } cond_t;

    typedef struct packed {
        logic emit;
        logic src_tgt;
        logic rep;
        logic cyc;
        logic done;
        logic last;
    } emit_t;

    localparam emit_t EM_NONE    = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam emit_t EM_PLAIN   = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam emit_t EM_REP     = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    localparam emit_t EM_REP_END = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    localparam emit_t EM_JUMP    = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam emit_t EM_FIN     = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        emit_t em;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic restart;
    } ctl_t;

    typedef struct packed {
        logic seen;
        logic found;
        logic more_rows;
        logic more_all;
        logic finished;
    } sts_t;

    localparam step_t S_IDLE      = 5'd0;
    localparam step_t S_CHK_FIN   = 5'd1;
    localparam step_t S_STEP      = 5'd2;
    localparam step_t S_TEST      = 5'd3;
    localparam step_t S_EMIT_NEW  = 5'd4;
    localparam step_t S_SRCH_INIT = 5'd5;
    localparam step_t S_SRCH_RD   = 5'd6;
    localparam step_t S_SRCH_CHK  = 5'd7;
    localparam step_t S_SRCH_NEXT = 5'd8;
    localparam step_t S_NONE      = 5'd9;
    localparam step_t S_FOUND     = 5'd10;
    localparam step_t S_EMIT_REP  = 5'd11;
    localparam step_t S_EMIT_JMP  = 5'd12;
    localparam step_t S_CLR_INIT  = 5'd13;
    localparam step_t S_CLR_ROW   = 5'd14;
    localparam step_t S_CLR_END   = 5'd15;
    localparam step_t S_EMIT_RST  = 5'd16;
    localparam step_t S_FIN       = 5'd17;
    localparam step_t S_LAST      = S_FIN;

    function automatic uword_t uw(op_t op, cond_t cond, step_t target, emit_t em);
        uword_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.em     = em;
        return w;
    endfunction

    function automatic uword_t ucode(step_t pc);
        uword_t w;
        unique case (pc)
            S_IDLE:      w = uw(OP_ACCEPT,   C_IN_RESTART,  S_CLR_INIT, EM_NONE);
            S_CHK_FIN:   w = uw(OP_NOP,      C_FINISHED,    S_FIN,      EM_NONE);
            S_STEP:      w = uw(OP_STEP,     C_NONE,        S_IDLE,     EM_NONE);
            S_TEST:      w = uw(OP_MARK,     C_SEEN,        S_SRCH_INIT, EM_NONE);
            S_EMIT_NEW:  w = uw(OP_NOP,      C_ALWAYS,      S_IDLE,     EM_PLAIN);
            S_SRCH_INIT: w = uw(OP_ROW_ZERO, C_NONE,        S_IDLE,     EM_NONE);
            S_SRCH_RD:   w = uw(OP_READ_ROW, C_NONE,        S_IDLE,     EM_NONE);
            S_SRCH_CHK:  w = uw(OP_NOP,      C_FOUND,       S_FOUND,    EM_NONE);
            S_SRCH_NEXT: w = uw(OP_ROW_INC,  C_MORE_ROWS,   S_SRCH_RD,  EM_NONE);
            S_NONE:      w = uw(OP_SET_FIN,  C_ALWAYS,      S_IDLE,     EM_REP_END);
            S_FOUND:     w = uw(OP_TAKE_TGT, C_NONE,        S_IDLE,     EM_NONE);
            S_EMIT_REP:  w = uw(OP_NOP,      C_NONE,        S_IDLE,     EM_REP);
            S_EMIT_JMP:  w = uw(OP_LOAD_TGT, C_ALWAYS,      S_IDLE,     EM_JUMP);
            S_CLR_INIT:  w = uw(OP_CLR_INIT, C_NONE,        S_IDLE,     EM_NONE);
            S_CLR_ROW:   w = uw(OP_CLR_WR,   C_MORE_ALL,    S_CLR_ROW,  EM_NONE);
            S_CLR_END:   w = uw(OP_NOP,      C_NOT_RESTART, S_IDLE,     EM_NONE);
            S_EMIT_RST:  w = uw(OP_NOP,      C_ALWAYS,      S_IDLE,     EM_PLAIN);
            S_FIN:       w = uw(OP_NOP,      C_ALWAYS,      S_IDLE,     EM_FIN);
            default:     w = uw(OP_NOP,      C_ALWAYS,      S_IDLE,     EM_NONE);
        endcase
        return w;
    endfunction

endpackage

[design/hcsw_dp.sv]
// Datapath of the walker: current state, CA step logic, visited-map memory
// and row search. Driven by control words from the top level; uses hcsw_pkg.
module hcsw_dp
    import hcsw_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctl_t                       ctl,
    input  logic [CNT_W-1:0]           cell_count,
    input  logic [RULE_CELLS*RULE_W-1:0] rules,
    output sts_t                       sts,
    output logic [CELLS_W-1:0]         cur_cells,
    output logic [CELLS_W-1:0]         tgt_cells
);

    localparam int STATE_W  = (MAX_CELLS < RULE_CELLS) ? MAX_CELLS : RULE_CELLS;
    localparam int BIT_W    = (STATE_W > 5) ? 5 : STATE_W - 1;
    localparam int RIDX_W   = STATE_W - BIT_W;
    localparam int ROW_W    = 1 << BIT_W;
    localparam int NUM_ROWS = 1 << RIDX_W;

    logic [STATE_W-1:0] cur_reg, cur_next;
    logic [STATE_W-1:0] tgt_reg, tgt_next;
    logic [RIDX_W-1:0]  row_reg, row_next;
    logic               fin_reg, fin_next;
    logic [ROW_W-1:0]   rdata_reg;

    logic [ROW_W-1:0]   map_mem [NUM_ROWS];

    logic [CNT_W-1:0]   n_use;
    logic [STATE_W-1:0] lim;
    logic [STATE_W-1:0] stepped;
    logic [RIDX_W-1:0]  lim_row;
    logic [BIT_W-1:0]   lim_low;
    logic [RIDX_W-1:0]  cur_row;
    logic [BIT_W-1:0]   cur_bit;
    logic [ROW_W-1:0]   vmask;
    logic [ROW_W-1:0]   cand;
    logic [BIT_W-1:0]   found_bit;

    logic               we;
    logic [RIDX_W-1:0]  waddr;
    logic [ROW_W-1:0]   wdata;
    logic               re;
    logic [RIDX_W-1:0]  raddr;

    function automatic logic [STATE_W-1:0] ca_step(
        logic [STATE_W-1:0] s,
        logic [CNT_W-1:0] n,
        logic [RULE_CELLS*RULE_W-1:0] rl
    );
        logic [STATE_W-1:0] nx;
        logic               l;
        logic               c;
        logic               r;
        logic [RULE_W-1:0]  rule;
        nx = '0;
        for (int i = 0; i < STATE_W; i++)
        begin
            l    = (i > 0) ? s[(i > 0) ? i - 1 : 0] : 1'b0;
            c    = s[i];
            r    = ((i + 1) < int'(n)) ? s[(i + 1 < STATE_W) ? i + 1 : i] : 1'b0;
            rule = rl[i*RULE_W +: RULE_W];
            nx[i] = rule[{l, c, r}];
        end
        return nx;
    endfunction

    always_comb
    begin
        if (cell_count < CNT_W'(2))
            n_use = CNT_W'(2);
        else if (cell_count > CNT_W'(STATE_W))
            n_use = CNT_W'(STATE_W);
        else
            n_use = cell_count;
    end

    assign lim     = ~({STATE_W{1'b1}} << n_use);
    assign stepped = ca_step(cur_reg & lim, n_use, rules) & lim;
    assign lim_row = lim[STATE_W-1:BIT_W];
    assign lim_low = lim[BIT_W-1:0];
    assign cur_row = cur_reg[STATE_W-1:BIT_W];
    assign cur_bit = cur_reg[BIT_W-1:0];

    always_comb
    begin
        for (int b = 0; b < ROW_W; b++)
        begin
            vmask[b] = ((row_reg != lim_row) || (BIT_W'(b) <= lim_low))
                       && ((row_reg != '0) || (b != 0));
        end
    end

    assign cand = ~rdata_reg & vmask;

    always_comb
    begin
        found_bit = '0;
        for (int b = ROW_W - 1; b >= 0; b--)
        begin
            if (cand[b])
                found_bit = BIT_W'(b);
        end
    end

    always_comb
    begin
        we       = 1'b0;
        waddr    = row_reg;
        wdata    = rdata_reg;
        re       = 1'b0;
        raddr    = row_reg;
        cur_next = cur_reg;
        tgt_next = tgt_reg;
        row_next = row_reg;
        fin_next = fin_reg;
        unique case (ctl.op)
            OP_STEP:
            begin
                cur_next = stepped;
                re       = 1'b1;
                raddr    = stepped[STATE_W-1:BIT_W];
            end
            OP_MARK:
            begin
                we    = 1'b1;
                waddr = cur_row;
                wdata = rdata_reg | (ROW_W'(1) << cur_bit);
            end
            OP_ROW_ZERO:
            begin
                row_next = '0;
            end
            OP_READ_ROW:
            begin
                re = 1'b1;
            end
            OP_ROW_INC:
            begin
                row_next = row_reg + RIDX_W'(1);
            end
            OP_SET_FIN:
            begin
                fin_next = 1'b1;
            end
            OP_TAKE_TGT:
            begin
                tgt_next = {row_reg, found_bit};
                we       = 1'b1;
                wdata    = rdata_reg | (ROW_W'(1) << found_bit);
            end
            OP_LOAD_TGT:
            begin
                cur_next = tgt_reg;
            end
            OP_CLR_INIT:
            begin
                row_next = '0;
                cur_next = '0;
                fin_next = 1'b0;
            end
            OP_CLR_WR:
            begin
                we       = 1'b1;
                wdata    = ROW_W'(ctl.restart && (row_reg == '0));
                row_next = row_reg + RIDX_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            row_reg <= '0;
            fin_reg <= 1'b0;
        end
        else
        begin
            cur_reg <= cur_next;
            row_reg <= row_next;
            fin_reg <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg <= tgt_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            map_mem[waddr] <= wdata;
        if (re)
            rdata_reg <= map_mem[raddr];
    end

    assign sts.seen      = rdata_reg[cur_bit];
    assign sts.found     = |cand;
    assign sts.more_rows = (row_reg != lim_row);
    assign sts.more_all  = (row_reg != '1);
    assign sts.finished  = fin_reg;

    assign cur_cells = CELLS_W'(cur_reg);
    assign tgt_cells = CELLS_W'(tgt_reg);

endmodule

[design/hybrid_ca_state_space_walker.sv]
// Top level of the hybrid CA state-space walker: microcode sequencer,
// configuration registers and output register. Uses hcsw_pkg and hcsw_dp.
//
// Walks every state of a hybrid cellular automaton with null boundaries, one
// transaction per restart or advance request. An advance to a new state runs
// the check, step, test and emit steps. When the next state was already
// visited, the sequencer scans the visited map for the smallest unvisited
// nonzero state, row by row (32-bit rows at the default) from row 0 up to the
// last row in use, then delivers the repeat and the jump target as two
// results, or a single repeat marked done and last if none is left. A restart
// clears the whole map, one row per cycle: 2^(min(MAX_CELLS,16)-5) rows (2048
// at the default) for MAX_CELLS above 5. The same clearing pass runs after
// reset, before the first input transaction is taken; configuration writes
// are taken at any time. The map memory has one read and one write port (one
// row read and one row write per cycle). A new input transaction is accepted
// while the last result still waits in the output register.
module hybrid_ca_state_space_walker
    import hcsw_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CELLS_W-1:0]    cells,
    output logic                  repeat_hit,
    output logic                  cycle_start,
    output logic                  done_res,
    output logic                  last
);

    step_t                 upc_reg, upc_next;
    logic                  restart_reg, restart_next;
    logic [CNT_W-1:0]      cell_count_reg;
    logic [CFG_DATA_W-1:0] rules_low_reg;
    logic [CFG_DATA_W-1:0] rules_high_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [CELLS_W-1:0]    cells_reg;
    logic                  rep_reg;
    logic                  cyc_reg;
    logic                  done_reg;
    logic                  last_reg;

    uword_t                uword;
    logic                  hold;
    logic                  jump;
    logic                  emit_go;
    ctl_t                  ctl;
    sts_t                  sts;
    logic [CELLS_W-1:0]    cur_cells;
    logic [CELLS_W-1:0]    tgt_cells;

    hcsw_dp #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cell_count (cell_count_reg),
        .rules      ({rules_high_reg, rules_low_reg}),
        .sts        (sts),
        .cur_cells  (cur_cells),
        .tgt_cells  (tgt_cells)
    );

    assign uword = ucode(upc_reg);

    // hold the step while waiting for input or for the output register
    assign hold = ((uword.op == OP_ACCEPT) && !in_valid)
                  || (uword.em.emit && out_valid_reg && !out_ready);

    always_comb
    begin
        case (uword.cond)
            C_ALWAYS:      jump = 1'b1;
            C_IN_RESTART:  jump = restart;
            C_FINISHED:    jump = sts.finished;
            C_SEEN:        jump = sts.seen;
            C_FOUND:       jump = sts.found;
            C_MORE_ROWS:   jump = sts.more_rows;
            C_MORE_ALL:    jump = sts.more_all;
            C_NOT_RESTART: jump = !restart_reg;
            default:       jump = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
            upc_next = upc_reg;
        else if (jump)
            upc_next = uword.target;
        else
            upc_next = upc_reg + STEP_W'(1);
    end

    assign in_ready     = (uword.op == OP_ACCEPT);
    assign restart_next = ((uword.op == OP_ACCEPT) && in_valid) ? restart : restart_reg;
    assign ctl.op       = hold ? OP_NOP : uword.op;
    assign ctl.restart  = restart_reg;
    assign emit_go      = uword.em.emit && !hold;

    always_comb
    begin
        if (emit_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= S_CLR_INIT;
            restart_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            restart_reg   <= restart_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            cells_reg <= uword.em.src_tgt ? tgt_cells : cur_cells;
            rep_reg   <= uword.em.rep;
            cyc_reg   <= uword.em.cyc;
            done_reg  <= uword.em.done;
            last_reg  <= uword.em.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_count_reg <= CNT_W'(16);
            rules_low_reg  <= '0;
            rules_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CELL_COUNT: cell_count_reg <= cfg_data[CNT_W-1:0];
                REG_RULES_LOW:  rules_low_reg  <= cfg_data;
                REG_RULES_HIGH: rules_high_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign cells       = cells_reg;
    assign repeat_hit  = rep_reg;
    assign cycle_start = cyc_reg;
    assign done_res    = done_reg;
    assign last        = last_reg;

    a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg <= S_LAST)
        else $error("step counter outside program");

    a_rep_cyc_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(rep_reg && cyc_reg))
        else $error("repeat and cycle start on one result");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> last_reg)
        else $error("done result not marked last");

    a_jump_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cyc_reg) |-> (last_reg && (cells_reg != '0)))
        else $error("cycle start on zero state or not last");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (upc_reg == S_CHK_FIN || upc_reg == S_CLR_INIT))
        else $error("accepted transaction not dispatched");

endmodule
